// ===== rtl/itf_pkg.sv =====
// Shared types, constants and helpers for the integer-to-text formatter.
package itf_pkg;

  localparam int VALUE_W    = 64;
  localparam int MAX_WIDTH  = 40;
  localparam int NUM_DIGITS = 22;          // digit store depth, fits 64-bit octal
  localparam int DEC_DIGITS = 20;          // BCD digits for a 64-bit value
  localparam int OCT_W      = 3 * NUM_DIGITS;
  localparam int HEX_W      = 4 * NUM_DIGITS;
  localparam int IDX_W      = $clog2(NUM_DIGITS);

  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_X     = 8'h78;
  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_PLUS  = 8'h2b;
  localparam logic [7:0] ASCII_MINUS = 8'h2d;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_UA    = 8'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_PREFIX,
    ST_PAD,
    ST_DIGITS,
    ST_TRAIL
  } state_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_SIGN,
    PFX_HEX
  } prefix_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {4'b0, d};
    end else begin
      c = (lower ? ASCII_LA : ASCII_UA) + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// ===== rtl/integer_to_text_formatter.sv =====
// Top level of the integer-to-text formatter: digit conversion and character sequencer.
//
//   channel | direction | beat                                     | handshake
//   --------+-----------+------------------------------------------+---------------------
//   input   | in        | value, base_sel, field_width, flags      | in_valid / in_ready
//   output  | out       | out_char, last_char (one per character)  | out_valid / out_ready
//
// Flow: decimal runs shift-add-3 conversion over all 64 value bits; octal and hex load
// their digits directly. A scan then finds the leading digit, one digit a cycle.
// Emission is one character a cycle while the output register drains, plus an idle step
// to close each prefix or pad segment. in_ready is high only in idle.
// Reset: rst, synchronous, clears the sequencer and the output valid.
// Stalls: out_ready low holds the output register and freezes emission; a new input
// beat may be taken while the last character still waits in the output register.
module integer_to_text_formatter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value,
  input  logic [1:0]  base_sel,
  input  logic [5:0]  field_width,
  input  logic        lower_case,
  input  logic        show_plus,
  input  logic        negative,
  input  logic        alt_form,
  input  logic        left_align,
  input  logic        zero_pad,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        last_char
);

  itf_pkg::state_t  state, state_next;

  // digit store, least significant digit at index 0
  logic [3:0] digs [itf_pkg::NUM_DIGITS];
  logic [3:0] digs_next [itf_pkg::NUM_DIGITS];
  logic [3:0] adj [itf_pkg::DEC_DIGITS];

  logic [itf_pkg::VALUE_W-1:0] sh, sh_next;       // shift register feeding the BCD unit
  logic [5:0]  bit_cnt, bit_cnt_next;
  logic [itf_pkg::IDX_W-1:0] idx, idx_next;
  logic [5:0]  pad_cnt, pad_cnt_next;
  logic [1:0]  pre_pos, pre_pos_next;
  logic [1:0]  pre_len, pre_len_next;
  itf_pkg::prefix_t kind, kind_next;
  logic        neg, neg_next;
  logic        lower, lower_next;
  logic        zmode, zmode_next;                  // zero padding, right aligned
  logic        left, left_next;
  logic [5:0]  wsat, wsat_next;

  logic        out_valid_next;
  logic [7:0]  out_char_next;
  logic        last_char_next;

  logic        emit;
  logic        is_dec;
  logic        is_oct;
  itf_pkg::prefix_t in_kind;
  logic [1:0]  klen;
  logic signed [7:0] w;
  logic [itf_pkg::OCT_W-1:0] oct_ext;
  logic [itf_pkg::HEX_W-1:0] hex_ext;
  logic        trail_due;

  assign in_ready  = (state == itf_pkg::ST_IDLE);
  assign emit      = !out_valid || out_ready;
  assign is_dec    = (base_sel == itf_pkg::BASE_DEC);
  assign is_oct    = (base_sel == itf_pkg::BASE_OCT);
  assign oct_ext   = {{(itf_pkg::OCT_W - itf_pkg::VALUE_W){1'b0}}, value};
  assign hex_ext   = {{(itf_pkg::HEX_W - itf_pkg::VALUE_W){1'b0}}, value};
  assign trail_due = left && (pad_cnt != 6'd0);

  always_comb begin
    if (is_dec && (show_plus || negative)) begin
      in_kind = itf_pkg::PFX_SIGN;
    end else if (alt_form) begin
      in_kind = itf_pkg::PFX_HEX;
    end else begin
      in_kind = itf_pkg::PFX_NONE;
    end
  end

  always_comb begin
    case (kind)
      itf_pkg::PFX_SIGN: klen = 2'd1;
      itf_pkg::PFX_HEX:  klen = 2'd2;
      default:           klen = 2'd0;
    endcase
  end

  // remaining width once prefix (octal '0' excluded) and digits are taken off
  assign w = $signed({2'b0, wsat}) - $signed({6'b0, klen})
           - $signed({{(8 - itf_pkg::IDX_W){1'b0}}, idx}) - 8'sd1;

  // shift-add-3 correction, each BCD digit on its own
  always_comb begin
    for (int i = 0; i < itf_pkg::DEC_DIGITS; i++) begin
      adj[i] = (digs[i] >= 4'd5) ? (digs[i] + 4'd3) : digs[i];
    end
  end

  always_comb begin
    state_next     = state;
    digs_next      = digs;
    sh_next        = sh;
    bit_cnt_next   = bit_cnt;
    idx_next       = idx;
    pad_cnt_next   = pad_cnt;
    pre_pos_next   = pre_pos;
    pre_len_next   = pre_len;
    kind_next      = kind;
    neg_next       = neg;
    lower_next     = lower;
    zmode_next     = zmode;
    left_next      = left;
    wsat_next      = wsat;
    out_valid_next = out_valid && !out_ready;
    out_char_next  = out_char;
    last_char_next = last_char;

    case (state)
      itf_pkg::ST_IDLE: begin
        if (in_valid) begin
          kind_next  = in_kind;
          neg_next   = negative;
          lower_next = lower_case;
          zmode_next = zero_pad && !left_align;
          left_next  = left_align;
          wsat_next  = (field_width > 6'(itf_pkg::MAX_WIDTH)) ?
                       6'(itf_pkg::MAX_WIDTH) : field_width;
          case (in_kind)
            itf_pkg::PFX_SIGN: pre_len_next = 2'd1;
            itf_pkg::PFX_HEX:  pre_len_next = 2'd2;
            default:           pre_len_next = (is_oct && !(zero_pad && !left_align)) ?
                                              2'd1 : 2'd0;
          endcase
          idx_next = itf_pkg::IDX_W'(itf_pkg::NUM_DIGITS - 1);
          if (is_dec) begin
            for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
              digs_next[i] = 4'd0;
            end
            sh_next      = value;
            bit_cnt_next = 6'(itf_pkg::VALUE_W - 1);
            state_next   = itf_pkg::ST_CONV;
          end else if (is_oct) begin
            for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
              digs_next[i] = {1'b0, oct_ext[3*i +: 3]};
            end
            state_next = itf_pkg::ST_SCAN;
          end else begin
            for (int i = 0; i < itf_pkg::NUM_DIGITS; i++) begin
              digs_next[i] = hex_ext[4*i +: 4];
            end
            state_next = itf_pkg::ST_SCAN;
          end
        end
      end

      itf_pkg::ST_CONV: begin
        digs_next[0] = {adj[0][2:0], sh[itf_pkg::VALUE_W-1]};
        for (int i = 1; i < itf_pkg::DEC_DIGITS; i++) begin
          digs_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
        sh_next = {sh[itf_pkg::VALUE_W-2:0], 1'b0};
        if (bit_cnt == 6'd0) begin
          state_next = itf_pkg::ST_SCAN;
        end else begin
          bit_cnt_next = bit_cnt - 6'd1;
        end
      end

      itf_pkg::ST_SCAN: begin
        if (idx != '0 && digs[idx] == 4'd0) begin
          idx_next = idx - itf_pkg::IDX_W'(1);
        end else begin
          pad_cnt_next = (w > 8'sd0) ? w[5:0] : 6'd0;
          pre_pos_next = 2'd0;
          state_next   = (zmode || left) ? itf_pkg::ST_PREFIX : itf_pkg::ST_PAD;
        end
      end

      itf_pkg::ST_PREFIX: begin
        if (pre_pos == pre_len) begin
          state_next = zmode ? itf_pkg::ST_PAD : itf_pkg::ST_DIGITS;
        end else if (emit) begin
          out_valid_next = 1'b1;
          last_char_next = 1'b0;
          if (kind == itf_pkg::PFX_SIGN) begin
            out_char_next = neg ? itf_pkg::ASCII_MINUS : itf_pkg::ASCII_PLUS;
          end else begin
            out_char_next = (pre_pos == 2'd0) ? itf_pkg::ASCII_ZERO : itf_pkg::ASCII_X;
          end
          pre_pos_next = pre_pos + 2'd1;
        end
      end

      itf_pkg::ST_PAD: begin
        if (pad_cnt == 6'd0) begin
          state_next = zmode ? itf_pkg::ST_DIGITS : itf_pkg::ST_PREFIX;
        end else if (emit) begin
          out_valid_next = 1'b1;
          last_char_next = 1'b0;
          out_char_next  = zmode ? itf_pkg::ASCII_ZERO : itf_pkg::ASCII_SPACE;
          pad_cnt_next   = pad_cnt - 6'd1;
        end
      end

      itf_pkg::ST_DIGITS: begin
        if (emit) begin
          out_valid_next = 1'b1;
          out_char_next  = itf_pkg::digit_char(digs[idx], lower);
          last_char_next = (idx == '0) && !trail_due;
          if (idx == '0) begin
            state_next = trail_due ? itf_pkg::ST_TRAIL : itf_pkg::ST_IDLE;
          end else begin
            idx_next = idx - itf_pkg::IDX_W'(1);
          end
        end
      end

      itf_pkg::ST_TRAIL: begin
        if (emit) begin
          out_valid_next = 1'b1;
          out_char_next  = itf_pkg::ASCII_SPACE;
          last_char_next = (pad_cnt == 6'd1);
          pad_cnt_next   = pad_cnt - 6'd1;
          if (pad_cnt == 6'd1) begin
            state_next = itf_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_next = itf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= itf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    digs      <= digs_next;
    sh        <= sh_next;
    bit_cnt   <= bit_cnt_next;
    idx       <= idx_next;
    pad_cnt   <= pad_cnt_next;
    pre_pos   <= pre_pos_next;
    pre_len   <= pre_len_next;
    kind      <= kind_next;
    neg       <= neg_next;
    lower     <= lower_next;
    zmode     <= zmode_next;
    left      <= left_next;
    wsat      <= wsat_next;
    out_char  <= out_char_next;
    last_char <= last_char_next;
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted but block still ready");

  a_trail_left_only: assert property (@(posedge clk) disable iff (rst)
    (state == itf_pkg::ST_TRAIL) |-> (left && pad_cnt != 6'd0))
    else $error("trailing spaces outside left alignment");

  a_pad_right_only: assert property (@(posedge clk) disable iff (rst)
    (state == itf_pkg::ST_PAD) |-> !left)
    else $error("leading pad in left alignment");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (state == itf_pkg::ST_DIGITS && emit && idx == '0 && !trail_due)
    |=> (state == itf_pkg::ST_IDLE && out_valid && last_char))
    else $error("final digit not marked as last");
`endif

endmodule
